// ===== design/svm_pkg.sv =====
// Shared types and constants for the stereo voice mixer.
// No dependencies; imported by every module of the block.
package svm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int VOL_W    = 8;
    localparam int MST_W    = 9;
    localparam int SUM_W    = 24;
    localparam int MULA_W   = 24;
    localparam int MULB_W   = 10;
    localparam int PROD_W   = MULA_W + MULB_W;
    localparam int CFG_W    = 9;
    localparam int CIDX_W   = 2;

    localparam logic [MST_W-1:0] MASTER_RESET = 9'd256;

    typedef enum logic [CIDX_W-1:0] {
        CFG_MASTER = 2'd0,
        CFG_SWAP   = 2'd1,
        CFG_OUT8   = 2'd2,
        CFG_MONO   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sample_is_8bit;
        logic [VOL_W-1:0]           left_volume;
        logic [VOL_W-1:0]           right_volume;
        logic                       last_voice;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VOL_L,
        ST_VOL_R,
        ST_ACC_R,
        ST_MST_L,
        ST_MST_R,
        ST_SAT_R,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_VOICE_L,
        OP_VOICE_R,
        OP_MST_L,
        OP_MST_R
    } t_opsel;

    typedef struct packed {
        t_opsel op_sel;
        logic   idle;
        logic   acc_l;
        logic   acc_r;
        logic   sat_l;
        logic   sat_r;
        logic   load_out;
    } t_ctrl;

endpackage

// ===== design/svm_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on svm_pkg for operand and product widths.
module svm_mul (
    input  logic                               i_clk,
    input  logic signed [svm_pkg::MULA_W-1:0]  i_a,
    input  logic signed [svm_pkg::MULB_W-1:0]  i_b,
    output logic signed [svm_pkg::PROD_W-1:0]  o_prod
);
    import svm_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== design/svm_seq.sv =====
// Sequencer: steps the shared multiplier through voice and master passes.
// Depends on svm_pkg for state and control types.
module svm_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_beat,
    input  logic           i_last,
    input  logic           i_out_free,
    output svm_pkg::t_ctrl o_ctrl
);
    import svm_pkg::*;

    t_state r_state;
    t_state n_state;
    t_ctrl  w_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        w_ctrl          = '0;
        w_ctrl.op_sel   = OP_VOICE_L;
        unique case (r_state)
            ST_IDLE: begin
                w_ctrl.idle = 1'b1;
                if (i_in_beat) n_state = ST_VOL_L;
            end
            ST_VOL_L: begin
                w_ctrl.op_sel = OP_VOICE_L;
                n_state       = ST_VOL_R;
            end
            ST_VOL_R: begin
                w_ctrl.op_sel = OP_VOICE_R;
                w_ctrl.acc_l  = 1'b1;
                n_state       = ST_ACC_R;
            end
            ST_ACC_R: begin
                w_ctrl.acc_r = 1'b1;
                n_state      = i_last ? ST_MST_L : ST_IDLE;
            end
            ST_MST_L: begin
                w_ctrl.op_sel = OP_MST_L;
                n_state       = ST_MST_R;
            end
            ST_MST_R: begin
                w_ctrl.op_sel = OP_MST_R;
                w_ctrl.sat_l  = 1'b1;
                n_state       = ST_SAT_R;
            end
            ST_SAT_R: begin
                w_ctrl.sat_r = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                w_ctrl.load_out = i_out_free;
                if (i_out_free) n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ctrl = w_ctrl;

endmodule

// ===== design/stereo_voice_mixer.sv =====
// Stereo voice mixer: one voice beat in, one output beat per frame.
// A voice that does not end a frame stalls the input after accept while the
// sequencer steps through VOL_L, VOL_R and ACC_R; then it takes the next beat.
// The last voice of a frame then goes on through MST_L, MST_R, SAT_R and OUT
// until its result is in the output register, waiting in OUT while that register is still held by a stall.
// One multiplier does all four products in turn; that sets this order of states.
// Synchronous active-low reset: sums cleared, master 256, flags 0, no output.
module stereo_voice_mixer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // voice channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  svm_pkg::t_in_item              i_item,
    // frame channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output svm_pkg::t_out_item             o_item,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [svm_pkg::CIDX_W-1:0]     i_cfg_index,
    input  logic [svm_pkg::CFG_W-1:0]      i_cfg_data
);
    import svm_pkg::*;

    // configuration registers
    logic [MST_W-1:0] r_master;
    logic             r_swap;
    logic             r_out8;
    logic             r_mono;

    // held voice beat and running sums
    t_in_item                 r_item;
    logic signed [SUM_W-1:0]  r_left_sum;
    logic signed [SUM_W-1:0]  r_right_sum;
    logic signed [SAMPLE_W-1:0] r_sat_l;
    logic signed [SAMPLE_W-1:0] r_sat_r;

    // output register
    t_out_item r_out;
    logic      r_out_valid;

    t_ctrl                     w_ctrl;
    logic                      w_in_beat;
    logic                      w_out_free;
    logic signed [MULA_W-1:0]  w_mul_a;
    logic signed [MULB_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [8:0]         w_byte_val;
    logic signed [MULA_W-1:0]  w_voice_a;
    logic [VOL_W-1:0]          w_vol;
    logic signed [SUM_W-1:0]   w_part;
    logic signed [PROD_W-9:0]  w_shifted;
    logic signed [SAMPLE_W-1:0] w_sat;
    logic [SAMPLE_W-1:0]       w_fmt_l;
    logic [SAMPLE_W-1:0]       w_fmt_r;
    t_out_item                 w_frame;

    assign w_in_beat  = i_valid && w_ctrl.idle;
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = !w_ctrl.idle;

    svm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_beat  (w_in_beat),
        .i_last     (r_item.last_voice),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    // 8-bit voices: b below 128 stays, otherwise b - 255 (range -127..0)
    assign w_byte_val = $signed({1'b0, r_item.sample[7:0]})
                      - (r_item.sample[7] ? 9'sd255 : 9'sd0);
    assign w_voice_a  = r_item.sample_is_8bit
                      ? MULA_W'(w_byte_val)
                      : MULA_W'(r_item.sample);

    always_comb begin
        w_vol   = (w_ctrl.op_sel == OP_VOICE_R) ? r_item.right_volume : r_item.left_volume;
        w_mul_a = w_voice_a;
        w_mul_b = '0;
        unique case (w_ctrl.op_sel)
            OP_VOICE_L, OP_VOICE_R: begin
                w_mul_a = w_voice_a;
                // 8-bit voices use the volume rounded down to a multiple of 8
                w_mul_b = r_item.sample_is_8bit
                        ? $signed({2'b00, w_vol[7:3], 3'b000})
                        : $signed({2'b00, w_vol});
            end
            OP_MST_L: begin
                w_mul_a = r_left_sum;
                w_mul_b = $signed({1'b0, r_master});
            end
            OP_MST_R: begin
                w_mul_a = r_right_sum;
                w_mul_b = $signed({1'b0, r_master});
            end
        endcase
    end

    svm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // voice contribution: 16-bit voices floor-shift by 8, 8-bit ones are exact
    assign w_part = r_item.sample_is_8bit
                  ? w_prod[SUM_W-1:0]
                  : SUM_W'($signed(w_prod[SUM_W-1:8]));

    // master-scaled sum, floor-shift by 8, saturate to 16 bits
    assign w_shifted = w_prod[PROD_W-1:8];
    always_comb begin
        if (w_shifted > (PROD_W-8)'(32767)) begin
            w_sat = 16'sh7fff;
        end else if (w_shifted < -(PROD_W-8)'(32768)) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = w_shifted[SAMPLE_W-1:0];
        end
    end

    // 8-bit unsigned form: (v >>> 8) + 128 is the high byte with its top bit flipped
    assign w_fmt_l = r_out8 ? {8'h00, r_sat_l[15] ^ 1'b1, r_sat_l[14:8]} : r_sat_l;
    assign w_fmt_r = r_out8 ? {8'h00, r_sat_r[15] ^ 1'b1, r_sat_r[14:8]} : r_sat_r;

    always_comb begin
        if (r_mono) begin
            w_frame.out_left  = w_fmt_l;
            w_frame.out_right = '0;
        end else if (!r_out8 && r_swap) begin
            w_frame.out_left  = w_fmt_r;
            w_frame.out_right = w_fmt_l;
        end else begin
            w_frame.out_left  = w_fmt_l;
            w_frame.out_right = w_fmt_r;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master <= MASTER_RESET;
            r_swap   <= 1'b0;
            r_out8   <= 1'b0;
            r_mono   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MASTER: r_master <= i_cfg_data;
                CFG_SWAP:   r_swap   <= i_cfg_data[0];
                CFG_OUT8:   r_out8   <= i_cfg_data[0];
                CFG_MONO:   r_mono   <= i_cfg_data[0];
            endcase
        end
    end

    // sums: accumulate per voice, clear once the frame is handed over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_sum  <= '0;
            r_right_sum <= '0;
        end else if (w_ctrl.load_out) begin
            r_left_sum  <= '0;
            r_right_sum <= '0;
        end else begin
            if (w_ctrl.acc_l) r_left_sum  <= r_left_sum + w_part;
            if (w_ctrl.acc_r) r_right_sum <= r_right_sum + w_part;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_beat)       r_item  <= i_item;
        if (w_ctrl.sat_l)    r_sat_l <= w_sat;
        if (w_ctrl.sat_r)    r_sat_r <= w_sat;
        if (w_ctrl.load_out) r_out   <= w_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

`ifndef SYNTHESIS
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_ctrl.load_out))
        else $error("output beat appeared without a frame hand-over");

    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.load_out |=> (r_left_sum == '0) && (r_right_sum == '0))
        else $error("sums not cleared after frame hand-over");

    a_mono_right_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_ctrl.load_out) && r_mono |-> o_item.out_right == '0)
        else $error("mono frame has non-zero right sample");

    a_out8_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_ctrl.load_out) && r_out8 |-> o_item.out_left[15:8] == 8'h00)
        else $error("8-bit frame outside 0..255");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> !w_ctrl.idle)
        else $error("sequencer idle right after a voice beat");
`endif

endmodule
